@@ hdl/ipc_pkg.sv @@
// Shared types, register indexes and constants for the irrigation pump controller.
`default_nettype none

package ipc_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LOW_MOISTURE    = 3'd0,
        REG_HIGH_MOISTURE   = 3'd1,
        REG_READ_INTERVAL   = 3'd2,
        REG_AUTO_DURATION   = 3'd3,
        REG_MANUAL_DURATION = 3'd4,
        REG_START_MANUAL    = 3'd5
    } t_reg_idx;

    localparam logic [1:0] LED_IDLE    = 2'd0;
    localparam logic [1:0] LED_PUMPING = 2'd1;
    localparam logic [1:0] LED_FAULT   = 2'd2;

    localparam logic signed [11:0] TEMP_HIGH_LIMIT = 12'sd600;
    localparam logic signed [11:0] TEMP_LOW_LIMIT  = -12'sd200;

    localparam logic [9:0]  RST_LOW_MOISTURE    = 10'd300;
    localparam logic [9:0]  RST_HIGH_MOISTURE   = 10'd700;
    localparam logic [15:0] RST_READ_INTERVAL   = 16'd5;
    localparam logic [15:0] RST_AUTO_DURATION   = 16'd60;
    localparam logic [15:0] RST_MANUAL_DURATION = 16'd30;
    localparam logic        RST_START_MANUAL    = 1'b0;

    typedef struct packed {
        logic [9:0]  low_moisture;
        logic [9:0]  high_moisture;
        logic [15:0] read_interval;
        logic [15:0] auto_duration;
        logic [15:0] manual_duration;
        logic        start_manual;
    } t_cfg;

    typedef struct packed {
        logic [31:0]        time_now;
        logic               mode_button;
        logic               water_button;
        logic [9:0]         soil_sample;
        logic signed [11:0] temp_sample;
    } t_item;

    typedef struct packed {
        logic               mode;
        logic               pump;
        logic [1:0]         led;
        logic [31:0]        run_start;
        logic [31:0]        last_read;
        logic [9:0]         held_soil;
        logic signed [11:0] held_temp;
    } t_state;

endpackage

`default_nettype wire

@@ hdl/ipc_cfg_regs.sv @@
// Configuration register file for the irrigation pump controller.
`default_nettype none

module ipc_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ipc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [ipc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output ipc_pkg::t_cfg                        o_cfg
);

    ipc_pkg::t_cfg r_cfg;
    ipc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                ipc_pkg::REG_LOW_MOISTURE:    n_cfg.low_moisture    = i_cfg_data[9:0];
                ipc_pkg::REG_HIGH_MOISTURE:   n_cfg.high_moisture   = i_cfg_data[9:0];
                ipc_pkg::REG_READ_INTERVAL:   n_cfg.read_interval   = i_cfg_data;
                ipc_pkg::REG_AUTO_DURATION:   n_cfg.auto_duration   = i_cfg_data;
                ipc_pkg::REG_MANUAL_DURATION: n_cfg.manual_duration = i_cfg_data;
                ipc_pkg::REG_START_MANUAL:    n_cfg.start_manual    = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_moisture    <= ipc_pkg::RST_LOW_MOISTURE;
            r_cfg.high_moisture   <= ipc_pkg::RST_HIGH_MOISTURE;
            r_cfg.read_interval   <= ipc_pkg::RST_READ_INTERVAL;
            r_cfg.auto_duration   <= ipc_pkg::RST_AUTO_DURATION;
            r_cfg.manual_duration <= ipc_pkg::RST_MANUAL_DURATION;
            r_cfg.start_manual    <= ipc_pkg::RST_START_MANUAL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ hdl/ipc_step.sv @@
// Combinational next-state logic for one control step.
`default_nettype none

module ipc_step (
    input  wire ipc_pkg::t_cfg   i_cfg,
    input  wire ipc_pkg::t_state i_state,
    input  wire ipc_pkg::t_item  i_item,
    output ipc_pkg::t_state      o_state
);

    logic        w_request;
    logic        w_latch;
    logic [31:0] w_since_read;
    logic [31:0] w_elapsed;
    logic [15:0] w_allowed;
    logic        w_stop;

    always_comb begin
        o_state = i_state;

        // mode button; entering manual stops the pump
        if (i_item.mode_button) begin
            if (!i_state.mode) begin
                o_state.mode = 1'b1;
                if (i_state.pump) begin
                    o_state.pump      = 1'b0;
                    o_state.run_start = '0;
                    o_state.led       = ipc_pkg::LED_IDLE;
                end
            end else begin
                o_state.mode = 1'b0;
            end
        end
        w_request = i_item.water_button && o_state.mode;

        w_since_read = i_item.time_now - i_state.last_read;
        w_latch      = (w_since_read >= {16'd0, i_cfg.read_interval});
        if (w_latch) begin
            o_state.held_soil = i_item.soil_sample;
            o_state.held_temp = i_item.temp_sample;
            o_state.last_read = i_item.time_now;
        end

        if (!o_state.mode && (o_state.held_soil < i_cfg.low_moisture) && !o_state.pump) begin
            o_state.pump      = 1'b1;
            o_state.run_start = i_item.time_now;
            o_state.led       = ipc_pkg::LED_PUMPING;
        end

        if (w_request) begin
            if (!o_state.pump) begin
                o_state.pump = 1'b1;
                o_state.led  = ipc_pkg::LED_PUMPING;
            end
            o_state.run_start = i_item.time_now;
        end

        w_elapsed = i_item.time_now - o_state.run_start;
        w_allowed = o_state.mode ? i_cfg.manual_duration : i_cfg.auto_duration;
        w_stop    = o_state.pump &&
                    ((o_state.held_soil > i_cfg.high_moisture) ||
                     ((o_state.run_start != '0) && (w_elapsed >= {16'd0, w_allowed})));

        // a threshold or timeout stop skips the temperature check
        if (w_stop) begin
            o_state.pump      = 1'b0;
            o_state.run_start = '0;
            o_state.led       = ipc_pkg::LED_IDLE;
        end else if ((o_state.held_temp > ipc_pkg::TEMP_HIGH_LIMIT) ||
                     (o_state.held_temp < ipc_pkg::TEMP_LOW_LIMIT)) begin
            o_state.led = ipc_pkg::LED_FAULT;
        end
    end

endmodule

`default_nettype wire

@@ hdl/irrigation_pump_controller_top.sv @@
// Irrigation pump controller: hysteresis on/off pump control with run timeout.
// Inputs are captured in the input register; the step result is held in the result register.
// Throughput: one transaction per cycle, unless both registers are full and the output is stalled.
// The result register feeds the input register's hold, so input stalls only when both are full.
// Reset (synchronous, active low) loads register defaults, auto mode, pump off, normal LED.
`default_nettype none

module irrigation_pump_controller_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [31:0]                     i_time_now,
    input  wire logic                            i_mode_button,
    input  wire logic                            i_water_button,
    input  wire logic [9:0]                      i_soil_sample,
    input  wire logic signed [11:0]              i_temp_sample,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_pump_on,
    output logic                                 o_manual_mode,
    output logic [1:0]                           o_led_code,
    input  wire logic                            i_cfg_we,
    input  wire logic [ipc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [ipc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    ipc_pkg::t_cfg   w_cfg;
    ipc_pkg::t_state r_state;
    ipc_pkg::t_state w_next;
    ipc_pkg::t_item  r_item;
    logic            r_s1_valid;
    logic            r_out_valid;
    logic            r_pump_on;
    logic            r_manual_mode;
    logic [1:0]      r_led_code;
    logic            w_advance;
    logic            w_in_accept;
    logic            w_mode_load;

    ipc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    ipc_step u_step (
        .i_cfg  (w_cfg),
        .i_state(r_state),
        .i_item (r_item),
        .o_state(w_next)
    );

    assign w_advance   = r_s1_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall  = r_s1_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_mode_load = i_cfg_we && (i_cfg_index == ipc_pkg::REG_START_MANUAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_item.time_now     <= i_time_now;
            r_item.mode_button  <= i_mode_button;
            r_item.water_button <= i_water_button;
            r_item.soil_sample  <= i_soil_sample;
            r_item.temp_sample  <= i_temp_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode      <= ipc_pkg::RST_START_MANUAL;
            r_state.pump      <= 1'b0;
            r_state.led       <= ipc_pkg::LED_IDLE;
            r_state.run_start <= '0;
            r_state.last_read <= '0;
            r_state.held_soil <= '0;
            r_state.held_temp <= '0;
        end else if (w_advance) begin
            r_state <= w_next;
        end else if (w_mode_load) begin
            r_state.mode <= i_cfg_data[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_pump_on     <= w_next.pump;
            r_manual_mode <= w_next.mode;
            r_led_code    <= w_next.led;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pump_on     = r_pump_on;
    assign o_manual_mode = r_manual_mode;
    assign o_led_code    = r_led_code;

    a_off_no_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.pump |-> (r_state.run_start == '0))
        else $error("pump off with run timer armed");

    a_watering_pump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.led == ipc_pkg::LED_PUMPING) |-> r_state.pump)
        else $error("watering LED with pump off");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a full, stalled pipeline");

    a_pump_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_state.pump))
        else $error("pump state changed without a step");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the irrigation pump controller: directed table plus random phases.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DUT_LATENCY    = 2;
    localparam int NUM_PHASES     = 6;
    localparam int PHASE_ITEMS    = 125;
    localparam int DRAIN_LIMIT    = 20000;

    localparam int STALL_NONE     = 0;
    localparam int STALL_LIGHT    = 1;
    localparam int STALL_PERIODIC = 2;
    localparam int STALL_HEAVY    = 3;

    localparam logic [ipc_pkg::CFG_INDEX_W-1:0] REG_SPARE = 3'd6;

    typedef struct packed {
        logic       pump;
        logic       manual;
        logic [1:0] led;
    } t_pump_status;

    typedef struct {
        ipc_pkg::t_item it;
        bit             typed;
        t_pump_status   st;
    } t_dir_row;

    logic                            i_clk          = 1'b0;
    logic                            i_rst_n        = 1'b0;
    logic                            i_in_valid     = 1'b0;
    logic                            o_in_stall;
    logic [31:0]                     i_time_now     = '0;
    logic                            i_mode_button  = 1'b0;
    logic                            i_water_button = 1'b0;
    logic [9:0]                      i_soil_sample  = '0;
    logic signed [11:0]              i_temp_sample  = '0;
    logic                            o_out_valid;
    logic                            i_out_stall    = 1'b0;
    logic                            o_pump_on;
    logic                            o_manual_mode;
    logic [1:0]                      o_led_code;
    logic                            i_cfg_we       = 1'b0;
    logic [ipc_pkg::CFG_INDEX_W-1:0] i_cfg_index    = '0;
    logic [ipc_pkg::CFG_DATA_W-1:0]  i_cfg_data     = '0;

    irrigation_pump_controller_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_time_now     (i_time_now),
        .i_mode_button  (i_mode_button),
        .i_water_button (i_water_button),
        .i_soil_sample  (i_soil_sample),
        .i_temp_sample  (i_temp_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pump_on      (o_pump_on),
        .o_manual_mode  (o_manual_mode),
        .o_led_code     (o_led_code),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    ipc_pkg::t_cfg   regs;
    ipc_pkg::t_state ctl;
    t_pump_status    status_q[$];
    t_dir_row        dir_rows[$];
    logic [31:0]     sim_secs = '0;
    int              stall_style = STALL_NONE;
    int unsigned     stall_tick = 0;
    int              err_count = 0;
    int              items_sent = 0;
    int              results_checked = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("timeout: run did not complete");
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    // ---------------- controller model ----------------
    function automatic void pump_begin(input logic [31:0] now);
        if (!ctl.pump) begin
            ctl.pump      = 1'b1;
            ctl.run_start = now;
            ctl.led       = ipc_pkg::LED_PUMPING;
        end
    endfunction

    function automatic void pump_halt();
        if (ctl.pump) begin
            ctl.pump      = 1'b0;
            ctl.run_start = '0;
            ctl.led       = ipc_pkg::LED_IDLE;
        end
    endfunction

    function automatic t_pump_status step_controller(input ipc_pkg::t_item it);
        logic         request;
        logic         halted;
        logic [31:0]  allowed;
        t_pump_status st;
        halted = 1'b0;
        if (it.mode_button) begin
            if (!ctl.mode) begin
                ctl.mode = 1'b1;
                pump_halt();
            end else begin
                ctl.mode = 1'b0;
            end
        end
        request = it.water_button && ctl.mode;
        if (it.time_now - ctl.last_read >= {16'd0, regs.read_interval}) begin
            ctl.held_soil = it.soil_sample;
            ctl.held_temp = it.temp_sample;
            ctl.last_read = it.time_now;
        end
        if (!ctl.mode && ctl.held_soil < regs.low_moisture)
            pump_begin(it.time_now);
        if (request) begin
            pump_begin(it.time_now);
            ctl.run_start = it.time_now;
        end
        if (ctl.pump) begin
            if (ctl.held_soil > regs.high_moisture) begin
                pump_halt();
                halted = 1'b1;
            end else if (ctl.run_start != '0) begin
                allowed = ctl.mode ? {16'd0, regs.manual_duration}
                                   : {16'd0, regs.auto_duration};
                if (it.time_now - ctl.run_start >= allowed) begin
                    pump_halt();
                    halted = 1'b1;
                end
            end
        end
        if (!halted && ($signed(ctl.held_temp) > ipc_pkg::TEMP_HIGH_LIMIT ||
                        $signed(ctl.held_temp) < ipc_pkg::TEMP_LOW_LIMIT))
            ctl.led = ipc_pkg::LED_FAULT;
        st.pump   = ctl.pump;
        st.manual = ctl.mode;
        st.led    = ctl.led;
        return st;
    endfunction

    // ---------------- drivers ----------------
    task automatic write_reg(input logic [ipc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            ipc_pkg::REG_LOW_MOISTURE:    regs.low_moisture    = data[9:0];
            ipc_pkg::REG_HIGH_MOISTURE:   regs.high_moisture   = data[9:0];
            ipc_pkg::REG_READ_INTERVAL:   regs.read_interval   = data;
            ipc_pkg::REG_AUTO_DURATION:   regs.auto_duration   = data;
            ipc_pkg::REG_MANUAL_DURATION: regs.manual_duration = data;
            ipc_pkg::REG_START_MANUAL: begin
                regs.start_manual = data[0];
                ctl.mode          = data[0];
            end
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [9:0] lo, input logic [9:0] hi,
                                input logic [15:0] ri, input logic [15:0] ad,
                                input logic [15:0] md, input logic sm, input bit spare);
        write_reg(ipc_pkg::REG_LOW_MOISTURE, {6'd0, lo});
        write_reg(ipc_pkg::REG_HIGH_MOISTURE, {6'd0, hi});
        write_reg(ipc_pkg::REG_READ_INTERVAL, ri);
        write_reg(ipc_pkg::REG_AUTO_DURATION, ad);
        write_reg(ipc_pkg::REG_MANUAL_DURATION, md);
        write_reg(ipc_pkg::REG_START_MANUAL, {15'd0, sm});
        if (spare)
            write_reg(REG_SPARE, 16'hFFFF);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_item(input ipc_pkg::t_item it, input bit typed,
                             input t_pump_status typed_st);
        t_pump_status st;
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_time_now     <= it.time_now;
        i_mode_button  <= it.mode_button;
        i_water_button <= it.water_button;
        i_soil_sample  <= it.soil_sample;
        i_temp_sample  <= it.temp_sample;
        do @(posedge i_clk); while (o_in_stall);
        st = step_controller(it);
        status_q.push_back(typed ? typed_st : st);
        items_sent++;
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_all_results();
        int guard;
        guard = 0;
        while (status_q.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (status_q.size() != 0) begin
            $display("timeout: %0d results still pending", status_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    endtask

    task automatic add_row(input logic [31:0] t, input logic mb, input logic wb,
                           input logic [9:0] soil, input logic signed [11:0] temp,
                           input bit typed, input logic p, input logic m, input logic [1:0] l);
        t_dir_row r;
        r.it.time_now     = t;
        r.it.mode_button  = mb;
        r.it.water_button = wb;
        r.it.soil_sample  = soil;
        r.it.temp_sample  = temp;
        r.typed           = typed;
        r.st.pump         = p;
        r.st.manual       = m;
        r.st.led          = l;
        dir_rows.push_back(r);
    endtask

    function automatic ipc_pkg::t_item random_item();
        ipc_pkg::t_item it;
        int             r;
        r = $urandom_range(0, 99);
        if (r < 80)
            sim_secs = sim_secs + $urandom_range(0, 12);
        else if (r < 90)
            sim_secs = sim_secs + $urandom_range(0, 200);
        else if (r < 95)
            sim_secs = $urandom();
        else
            sim_secs = sim_secs - $urandom_range(0, 30);
        it.time_now     = sim_secs;
        it.mode_button  = ($urandom_range(0, 99) < 8);
        it.water_button = ($urandom_range(0, 99) < 20);
        r = $urandom_range(0, 99);
        if (r < 25)
            it.soil_sample = 10'(int'(regs.low_moisture) + $urandom_range(0, 6) - 3);
        else if (r < 50)
            it.soil_sample = 10'(int'(regs.high_moisture) + $urandom_range(0, 6) - 3);
        else if (r < 92)
            it.soil_sample = 10'($urandom_range(0, 1000));
        else
            it.soil_sample = 10'($urandom_range(0, 1023));
        r = $urandom_range(0, 99);
        if (r < 80)
            it.temp_sample = 12'(int'($urandom_range(0, 1650)) - 400);
        else if (r < 90)
            it.temp_sample = 12'(($urandom_range(0, 1) ? 600 : -200) + int'($urandom_range(0, 4)) - 2);
        else
            it.temp_sample = 12'($urandom());
        return it;
    endfunction

    task automatic run_random(input int count);
        int           left;
        int           burst;
        bit           paused;
        t_pump_status none;
        none   = '0;
        left   = count;
        paused = 1'b0;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && left > 0) begin
                send_item(random_item(), 1'b0, none);
                burst--;
                left--;
            end
            if (!paused && left < count / 2) begin
                // hold off until the block has fully drained
                idle_cycles(1);
                wait_all_results();
                paused = 1'b1;
            end else if ($urandom_range(0, 3) != 0) begin
                idle_cycles($urandom_range(1, 6));
            end
        end
    endtask

    task automatic drain_to_idle();
        idle_cycles(1);
        wait_all_results();
        repeat (DUT_LATENCY + 2) @(posedge i_clk);
    endtask

    // ---------------- receiver stall ----------------
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 1;
        case (stall_style)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 99) < 30);
            STALL_PERIODIC: i_out_stall <= ((stall_tick % 7) < 3);
            default:        i_out_stall <= ($urandom_range(0, 99) < 75);
        endcase
    end

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin : result_check
        t_pump_status want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (status_q.size() == 0) begin
                report_mismatch("result transaction with nothing pending");
            end else begin
                want = status_q.pop_front();
                results_checked++;
                if (o_pump_on !== want.pump)
                    report_mismatch($sformatf("pump_on got %b want %b", o_pump_on, want.pump));
                if (o_manual_mode !== want.manual)
                    report_mismatch($sformatf("manual_mode got %b want %b",
                                              o_manual_mode, want.manual));
                if (o_led_code !== want.led)
                    report_mismatch($sformatf("led_code got %0d want %0d", o_led_code, want.led));
            end
        end
    end

    // ---------------- main sequence ----------------
    initial begin : main_seq
        int guard;
        regs.low_moisture    = ipc_pkg::RST_LOW_MOISTURE;
        regs.high_moisture   = ipc_pkg::RST_HIGH_MOISTURE;
        regs.read_interval   = ipc_pkg::RST_READ_INTERVAL;
        regs.auto_duration   = ipc_pkg::RST_AUTO_DURATION;
        regs.manual_duration = ipc_pkg::RST_MANUAL_DURATION;
        regs.start_manual    = ipc_pkg::RST_START_MANUAL;
        ctl      = '0;
        ctl.mode = ipc_pkg::RST_START_MANUAL;

        // time, mode btn, water btn, soil, temp, typed, pump, manual, led
        add_row(32'd0, 1'b0, 1'b0, 10'd500, 12'sd250, 1'b1, 1'b1, 1'b0, ipc_pkg::LED_PUMPING);
        add_row(32'd10, 1'b0, 1'b0, 10'd1000, 12'sd250, 1'b1, 1'b0, 1'b0, ipc_pkg::LED_IDLE);
        add_row(32'd20, 1'b0, 1'b0, 10'd0, 12'sd1250, 1'b1, 1'b1, 1'b0, ipc_pkg::LED_FAULT);
        add_row(32'd30, 1'b1, 1'b0, 10'd0, -12'sd400, 1'b1, 1'b0, 1'b1, ipc_pkg::LED_FAULT);
        add_row(32'd40, 1'b0, 1'b1, 10'd500, 12'sd200, 1'b1, 1'b1, 1'b1, ipc_pkg::LED_PUMPING);
        add_row(32'd75, 1'b0, 1'b0, 10'd500, 12'sd200, 1'b1, 1'b0, 1'b1, ipc_pkg::LED_IDLE);
        add_row(32'd76, 1'b1, 1'b1, 10'd500, 12'sd200, 1'b1, 1'b0, 1'b0, ipc_pkg::LED_IDLE);
        add_row(32'd77, 1'b0, 1'b1, 10'd500, 12'sd200, 1'b1, 1'b0, 1'b0, ipc_pkg::LED_IDLE);
        add_row(32'hFFFF_FFFF, 1'b0, 1'b0, 10'd1023, 12'sh7FF,
                1'b1, 1'b0, 1'b0, ipc_pkg::LED_FAULT);
        add_row(32'd4, 1'b0, 1'b0, 10'd100, 12'sh800, 1'b1, 1'b1, 1'b0, ipc_pkg::LED_FAULT);
        add_row(32'd64, 1'b0, 1'b0, 10'd100, 12'sd0, 1'b1, 1'b0, 1'b0, ipc_pkg::LED_IDLE);
        add_row(32'd65, 1'b0, 1'b0, 10'd100, 12'sd0, 1'b1, 1'b1, 1'b0, ipc_pkg::LED_PUMPING);
        add_row(32'd80, 1'b1, 1'b0, 10'd300, 12'sd600, 1'b0, 1'b0, 1'b0, ipc_pkg::LED_IDLE);
        add_row(32'd0, 1'b0, 1'b1, 10'd700, -12'sd200, 1'b0, 1'b0, 1'b0, ipc_pkg::LED_IDLE);
        add_row(32'd5000, 1'b0, 1'b0, 10'd700, 12'sd601, 1'b0, 1'b0, 1'b0, ipc_pkg::LED_IDLE);
        add_row(32'd5005, 1'b0, 1'b1, 10'd700, 12'sd601, 1'b0, 1'b0, 1'b0, ipc_pkg::LED_IDLE);
        add_row(32'd5010, 1'b0, 1'b0, 10'd701, -12'sd201, 1'b0, 1'b0, 1'b0, ipc_pkg::LED_IDLE);
        add_row(32'd5011, 1'b1, 1'b0, 10'd701, -12'sd201, 1'b0, 1'b0, 1'b0, ipc_pkg::LED_IDLE);
        add_row(32'd5020, 1'b0, 1'b0, 10'd299, 12'sd0, 1'b0, 1'b0, 1'b0, ipc_pkg::LED_IDLE);
        add_row(32'd5025, 1'b0, 1'b0, 10'd300, 12'sd0, 1'b0, 1'b0, 1'b0, ipc_pkg::LED_IDLE);
        add_row(32'd5080, 1'b0, 1'b0, 10'd300, 12'sd0, 1'b0, 1'b0, 1'b0, ipc_pkg::LED_IDLE);
        add_row(32'd5081, 1'b1, 1'b0, 10'd300, 12'sd0, 1'b0, 1'b0, 1'b0, ipc_pkg::LED_IDLE);
        add_row(32'd5082, 1'b1, 1'b1, 10'd300, 12'sd0, 1'b0, 1'b0, 1'b0, ipc_pkg::LED_IDLE);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        stall_style = STALL_LIGHT;
        foreach (dir_rows[k]) begin
            send_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].st);
            if ($urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(1, 3));
        end
        sim_secs = 32'd5100;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                drain_to_idle();
                case (ph)
                    1: program_regs(10'd400, 10'd600, 16'd0, 16'd20, 16'd10, 1'b1, 1'b0);
                    2: program_regs(10'd0, 10'd1000, 16'hFFFF, 16'd0, 16'd0, 1'b0, 1'b1);
                    3: program_regs(10'd1000, 10'd0, 16'd1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
                    default: program_regs(10'($urandom_range(0, 1000)),
                                          10'($urandom_range(0, 1000)),
                                          16'($urandom_range(0, 10)),
                                          16'($urandom_range(0, 80)),
                                          16'($urandom_range(0, 80)),
                                          1'($urandom_range(0, 1)), 1'b0);
                endcase
            end
            stall_style = ph % 4;
            run_random(PHASE_ITEMS);
        end

        idle_cycles(1);
        wait_all_results();
        guard = 0;
        while (guard < DUT_LATENCY + 8) begin
            @(posedge i_clk);
            guard++;
        end

        $display("Covered %0d control steps over %0d register settings, %0d results compared.",
                 items_sent, NUM_PHASES, results_checked);
        $display("Stimulus spanned threshold, timeout, wrap, manual and error-LED cases.");
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
